// File: src/utf8d_pkg.sv
// shared types and constants for the utf-8 stream decoder
// no dependencies; imported by every module of the block
`default_nettype none

package utf8d_pkg;

   localparam int CP_WIDTH     = 21;
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_WIDTH   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_WIDTH   = $clog2(QUEUE_DEPTH + 1);

   // result status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_INVALID   = 2'd1;
   localparam logic [1:0] ST_TRUNCATED = 2'd2;

   // class of a byte if it stands in lead position
   typedef enum logic [2:0] {
      LC_ASCII   = 3'd0,
      LC_TWO     = 3'd1,
      LC_THREE   = 3'd2,
      LC_FOUR    = 3'd3,
      LC_INVALID = 3'd4
   } lead_class_type;

   // one classified word as it sits in the queue
   typedef struct packed {
      logic [7:0]     data_byte;
      logic           final_byte;
      lead_class_type lead_class;
      logic [6:0]     lead_value;   // payload bits of the lead byte
      logic [1:0]     lead_pending; // continuation bytes that follow the lead
   } item_type;

endpackage

`default_nettype wire

// File: src/utf8d_front.sv
// front end: classifies each incoming byte by its lead pattern
// depends on utf8d_pkg
`default_nettype none

module utf8d_front (
   input  wire logic [7:0]         data_byte,
   input  wire logic               final_byte,
   output utf8d_pkg::item_type     item
);
   import utf8d_pkg::*;

   always_comb begin
      item.data_byte    = data_byte;
      item.final_byte   = final_byte;
      item.lead_value   = 7'd0;
      item.lead_pending = 2'd0;
      item.lead_class   = LC_INVALID;
      priority if (data_byte[7] == 1'b0) begin
         item.lead_class = LC_ASCII;
         item.lead_value = data_byte[6:0];
      end else if ((data_byte & 8'hE0) == 8'hC0) begin
         item.lead_class   = LC_TWO;
         item.lead_value   = {2'b00, data_byte[4:0]};
         item.lead_pending = 2'd1;
      end else if ((data_byte & 8'hF0) == 8'hE0) begin
         item.lead_class   = LC_THREE;
         item.lead_value   = {3'b000, data_byte[3:0]};
         item.lead_pending = 2'd2;
      end else if ((data_byte & 8'hF8) == 8'hF0) begin
         item.lead_class   = LC_FOUR;
         item.lead_value   = {4'b0000, data_byte[2:0]};
         item.lead_pending = 2'd3;
      end else begin
         item.lead_class = LC_INVALID;
      end
   end

endmodule

`default_nettype wire

// File: src/utf8d_queue.sv
// short queue of classified words between front end and back end
// depends on utf8d_pkg
`default_nettype none

module utf8d_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire utf8d_pkg::item_type push_item,
   input  wire logic                pop,
   output logic                     full,
   output logic                     not_empty,
   output utf8d_pkg::item_type      head_item
);
   import utf8d_pkg::*;

   item_type                slot_ff [QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_WIDTH-1:0]   count_ff, count_in;

   assign full      = (count_ff == QCNT_WIDTH'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_item = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// File: src/utf8d_back.sv
// back end: sequence state, code point assembly and result register
// depends on utf8d_pkg
`default_nettype none

module utf8d_back (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      item_valid,
   input  wire utf8d_pkg::item_type       item,
   output logic                           item_take,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic [utf8d_pkg::CP_WIDTH-1:0] rsp_code_point,
   output logic [1:0]                     rsp_status,
   output logic                           rsp_string_end
);
   import utf8d_pkg::*;

   logic [CP_WIDTH-1:0] partial_ff, partial_in;
   logic [1:0]          pending_ff, pending_in;
   logic                out_valid_ff, out_valid_in;
   logic [CP_WIDTH-1:0] out_cp_ff;
   logic [1:0]          out_status_ff;
   logic                out_end_ff;

   logic                emit;
   logic [CP_WIDTH-1:0] emit_cp;
   logic [1:0]          emit_status;
   logic                emit_end;
   logic [CP_WIDTH-1:0] shifted;
   logic [1:0]          pending_dec;

   // output slot is free when empty or being drained this cycle
   assign item_take = item_valid && (!out_valid_ff || !rsp_stall);

   assign shifted     = {partial_ff[CP_WIDTH-7:0], item.data_byte[5:0]};
   assign pending_dec = pending_ff - 2'd1;

   always_comb begin
      partial_in  = partial_ff;
      pending_in  = pending_ff;
      emit        = 1'b0;
      emit_cp     = '0;
      emit_status = ST_OK;
      emit_end    = item.final_byte;
      if (pending_ff == 2'd0) begin
         unique case (item.lead_class)
            LC_ASCII: begin
               emit    = 1'b1;
               emit_cp = CP_WIDTH'(item.lead_value);
            end
            LC_TWO, LC_THREE, LC_FOUR: begin
               if (item.final_byte) begin
                  emit        = 1'b1;
                  emit_status = ST_TRUNCATED;
                  partial_in  = '0;
                  pending_in  = 2'd0;
               end else begin
                  partial_in = CP_WIDTH'(item.lead_value);
                  pending_in = item.lead_pending;
               end
            end
            default: begin
               emit        = 1'b1;
               emit_status = ST_INVALID;
               partial_in  = '0;
            end
         endcase
      end else begin
         // continuation position: low six bits only, pattern not checked
         if (pending_dec == 2'd0) begin
            emit       = 1'b1;
            emit_cp    = shifted;
            partial_in = '0;
            pending_in = 2'd0;
         end else if (item.final_byte) begin
            emit        = 1'b1;
            emit_status = ST_TRUNCATED;
            partial_in  = '0;
            pending_in  = 2'd0;
         end else begin
            partial_in = shifted;
            pending_in = pending_dec;
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (!out_valid_ff || !rsp_stall) begin
         out_valid_in = item_take && emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff   <= '0;
         pending_ff   <= 2'd0;
         out_valid_ff <= 1'b0;
      end else begin
         if (item_take) begin
            partial_ff <= partial_in;
            pending_ff <= pending_in;
         end
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (item_take && emit) begin
         out_cp_ff     <= emit_cp;
         out_status_ff <= emit_status;
         out_end_ff    <= emit_end;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_code_point = out_cp_ff;
   assign rsp_status     = out_status_ff;
   assign rsp_string_end = out_end_ff;

endmodule

`default_nettype wire

// File: src/utf8_stream_decoder.sv
// utf-8 stream decoder: one byte per word in, one code point word out
// depends on utf8d_pkg, utf8d_front, utf8d_queue, utf8d_back
//
// usage:
//   req channel carries one raw byte of a utf-8 string per word, with
//   req_final_byte high on the last byte of the string. a word is taken at
//   a rising edge with req_valid high and req_stall low.
//   rsp channel gives a word when a code point completes (status ok), when
//   a lead byte is invalid (status 1, code point zero) or when the string
//   ends mid-sequence (status 2, code point zero, string_end high).
//   bytes that only extend a sequence give no word.
// path: a byte that completes a code point passes the queue and then the
//   result register before it shows on rsp.
// throughput: one byte per cycle unless a stall holds it back, set by the
//   per-byte state update in the back end; the two-entry queue lets the front
//   keep taking bytes while a result waits in the result register.
// stall: while rsp_stall is high the result register holds its word; once
//   the queue fills, req_stall rises. no word is lost or repeated.
// reset: synchronous, clears the queue, the result register and the
//   sequence state, so decoding restarts at a lead byte.
`default_nettype none

module utf8_stream_decoder (
   input  wire logic                      clock,
   input  wire logic                      reset,
   // byte input channel
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic [7:0]                req_data_byte,
   input  wire logic                      req_final_byte,
   // code point result channel
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic [utf8d_pkg::CP_WIDTH-1:0] rsp_code_point,
   output logic [1:0]                     rsp_status,
   output logic                           rsp_string_end
);
   import utf8d_pkg::*;

   item_type front_item;
   item_type head_item;
   logic     q_full;
   logic     q_not_empty;
   logic     q_pop;
   logic     req_take;

   // front end accepts whenever the queue has room
   assign req_stall = q_full;
   assign req_take  = req_valid && !q_full;

   // classify the byte by its lead pattern before queueing
   utf8d_front u_front (
      .data_byte  (req_data_byte),
      .final_byte (req_final_byte),
      .item       (front_item)
   );

   // decouples byte intake from result back-pressure
   utf8d_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_take),
      .push_item (front_item),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head_item (head_item)
   );

   // sequence state and registered result
   utf8d_back u_back (
      .clock          (clock),
      .reset          (reset),
      .item_valid     (q_not_empty),
      .item           (head_item),
      .item_take      (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_code_point (rsp_code_point),
      .rsp_status     (rsp_status),
      .rsp_string_end (rsp_string_end)
   );

   // an error result never carries a code point
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |-> (rsp_code_point == '0))
      else $error("error result with nonzero code point");

   // a truncation can only be reported at the end of a string
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_TRUNCATED) |-> rsp_string_end)
      else $error("truncation reported without string end");

   // input is only stalled when the back end has work waiting
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> q_not_empty)
      else $error("input stalled with empty queue");

   // a word is never taken from an empty queue
   assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_not_empty)
      else $error("pop from empty queue");

endmodule

`default_nettype wire

// File: tb/utf8_stream_decoder_test.sv
// self-checking testbench for utf8_stream_decoder: directed and random byte strings
// depends on utf8d_pkg and the utf8_stream_decoder rtl; a built-in predictor checks every word
`default_nettype none

module utf8_stream_decoder_test;
   import utf8d_pkg::*;

   // one byte word waiting to be sent, with a flag that holds it back until
   // every expected code point word has come out
   typedef struct {
      logic [7:0] data_byte;
      logic       final_byte;
      logic       drain_first;
   } byte_word_type;

   // one expected result word
   typedef struct {
      logic [CP_WIDTH-1:0] code_point;
      logic [1:0]          status;
      logic                string_end;
   } code_word_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [7:0]          req_data_byte = 8'h00;
   logic                req_final_byte = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [CP_WIDTH-1:0] rsp_code_point;
   logic [1:0]          rsp_status;
   logic                rsp_string_end;

   byte_word_type byte_backlog[$];     // words not yet put on the req channel
   code_word_type expected_points[$];  // predicted words, oldest first
   int            mismatch_count = 0;
   int            cycle_count = 0;

   // predictor state: code point bits gathered so far and continuation bytes left
   logic [CP_WIDTH-1:0] seq_value = '0;
   logic [1:0]          seq_left = 2'd0;

   utf8_stream_decoder dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_byte  (req_data_byte),
      .req_final_byte (req_final_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_code_point (rsp_code_point),
      .rsp_status     (rsp_status),
      .rsp_string_end (rsp_string_end)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // both sides run without idling in this window
   function automatic bit quiet_window();
      return cycle_count >= 250 && cycle_count < 450;
   endfunction

   function automatic bit take_a_break();
      return !quiet_window() && $urandom_range(0, 99) < 20;
   endfunction

   task automatic expect_word(input logic [CP_WIDTH-1:0] cp, input logic [1:0] st,
                              input logic fin);
      code_word_type w;
      w.code_point = cp;
      w.status     = st;
      w.string_end = fin;
      expected_points = {expected_points, w};
   endtask

   // decoder update for one accepted byte
   task automatic decode_byte(input logic [7:0] b, input logic fin);
      logic lead_started;
      lead_started = 1'b0;
      if (seq_left == 2'd0) begin
         if (!b[7]) begin
            // plain ascii: a word of its own
            expect_word({13'd0, b}, ST_OK, fin);
         end else if (b[7:5] == 3'b110) begin
            seq_value = {16'd0, b[4:0]};
            seq_left = 2'd1;
            lead_started = 1'b1;
         end else if (b[7:4] == 4'b1110) begin
            seq_value = {17'd0, b[3:0]};
            seq_left = 2'd2;
            lead_started = 1'b1;
         end else if (b[7:3] == 5'b11110) begin
            seq_value = {18'd0, b[2:0]};
            seq_left = 2'd3;
            lead_started = 1'b1;
         end else begin
            // stray continuation or 11111xxx in lead position
            seq_value = '0;
            expect_word('0, ST_INVALID, fin);
         end
         // multi-byte lead on the last byte of the string
         if (lead_started && fin) begin
            seq_value = '0;
            seq_left = 2'd0;
            expect_word('0, ST_TRUNCATED, 1'b1);
         end
      end else begin
         // any byte counts as a continuation here, only its low six bits matter
         seq_value = {seq_value[CP_WIDTH-7:0], b[5:0]};
         seq_left = seq_left - 2'd1;
         if (seq_left == 2'd0) begin
            expect_word(seq_value, ST_OK, fin);
            seq_value = '0;
         end else if (fin) begin
            // string ended mid-sequence
            seq_value = '0;
            seq_left = 2'd0;
            expect_word('0, ST_TRUNCATED, 1'b1);
         end
      end
   endtask

   // driver: one word on req at a time, held steady while stalled
   always @(posedge clock) begin
      byte_word_type issue_word;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            decode_byte(req_data_byte, req_final_byte);
         end
         if (!req_valid || !req_stall) begin
            if (byte_backlog.size() != 0 && !take_a_break() &&
                !(byte_backlog[0].drain_first && expected_points.size() != 0)) begin
               issue_word = byte_backlog.pop_front();
               req_valid <= 1'b1;
               req_data_byte <= issue_word.data_byte;
               req_final_byte <= issue_word.final_byte;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= take_a_break();
      end
   end

   // monitor: every accepted result word against the oldest prediction
   always @(posedge clock) begin
      code_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_points.size() == 0) begin
            $error("unexpected word: code_point %h status %0d string_end %0b",
                   rsp_code_point, rsp_status, rsp_string_end);
            mismatch_count++;
         end else begin
            want = expected_points.pop_front();
            if (rsp_code_point !== want.code_point) begin
               $error("code_point mismatch: expected %h, actual %h",
                      want.code_point, rsp_code_point);
               mismatch_count++;
            end
            if (rsp_status !== want.status) begin
               $error("status mismatch: expected %0d, actual %0d", want.status, rsp_status);
               mismatch_count++;
            end
            if (rsp_string_end !== want.string_end) begin
               $error("string_end mismatch: expected %0b, actual %0b",
                      want.string_end, rsp_string_end);
               mismatch_count++;
            end
         end
      end
   end

   task automatic queue_byte(input logic [7:0] b, input logic fin, input logic drain);
      byte_word_type w;
      w.data_byte   = b;
      w.final_byte  = fin;
      w.drain_first = drain;
      byte_backlog = {byte_backlog, w};
   endtask

   function automatic logic [7:0] cont_byte();
      return 8'h80 | 8'($urandom_range(0, 63));
   endfunction

   // one random string: mostly well-formed characters, some noise and
   // sometimes a sequence cut off by the end of the string
   task automatic queue_random_string(input logic drain);
      logic [7:0] s[$];
      int n_chars;
      int pick;
      int cut;
      n_chars = $urandom_range(1, 8);
      for (int i = 0; i < n_chars; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 32) begin
            s = {s, 8'($urandom_range(0, 127))};
         end else if (pick < 52) begin
            s = {s, 8'hC0 | 8'($urandom_range(0, 31))};
            s = {s, cont_byte()};
         end else if (pick < 70) begin
            s = {s, 8'hE0 | 8'($urandom_range(0, 15))};
            s = {s, cont_byte()};
            s = {s, cont_byte()};
         end else if (pick < 86) begin
            s = {s, 8'hF0 | 8'($urandom_range(0, 7))};
            s = {s, cont_byte()};
            s = {s, cont_byte()};
            s = {s, cont_byte()};
         end else begin
            // raw noise byte, lands in lead or continuation position alike
            s = {s, 8'($urandom_range(0, 255))};
         end
      end
      // sometimes end the string inside a multi-byte sequence
      if ($urandom_range(0, 99) < 15) begin
         cut = $urandom_range(0, 2);
         s = {s, 8'hF0 | 8'($urandom_range(0, 7))};
         for (int i = 0; i < cut; i++) s = {s, cont_byte()};
      end
      foreach (s[i]) queue_byte(s[i], i == s.size() - 1, drain && i == 0);
   endtask

   initial begin
      logic [7:0] directed[$];
      logic       directed_fin[$];
      // ascii extremes, the second closing a string
      directed = {8'h00, 8'h7F,
                  // two-, three- and four-byte characters
                  8'hC2, 8'hA9, 8'hE2, 8'h82, 8'hAC, 8'hF0, 8'h9F, 8'h98, 8'h80,
                  // largest 21-bit value, above the unicode range
                  8'hF7, 8'hBF, 8'hBF, 8'hBF,
                  // invalid leads, the last one closing a string
                  8'h80, 8'hF8, 8'hFF,
                  // multi-byte lead as the last byte
                  8'hC3,
                  // string ends after one of two continuation bytes
                  8'hE2, 8'h82,
                  // lead-looking byte taken as continuation
                  8'hC2, 8'hFF};
      directed_fin = {1'b0, 1'b1,
                      1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
                      1'b0, 1'b0, 1'b0, 1'b0,
                      1'b0, 1'b0, 1'b1,
                      1'b1,
                      1'b0, 1'b1,
                      1'b0, 1'b1};
      foreach (directed[i]) queue_byte(directed[i], directed_fin[i], 1'b0);

      // random part; hold off at its start and for strings queued around halfway
      queue_random_string(1'b1);
      while (byte_backlog.size() < 420) begin
         queue_random_string(byte_backlog.size() >= 220 && byte_backlog.size() < 232);
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (byte_backlog.size() != 0 || req_valid) @(posedge clock);
      while (expected_points.size() != 0) @(posedge clock);
      // leave room for a stray word after the pipeline drains
      repeat (20) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("** utf8_stream_decoder: PASSED **");
      end else begin
         $display("** utf8_stream_decoder: FAILED **");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2000000;
      $display("** utf8_stream_decoder: FAILED **");
      $finish;
   end

endmodule

`default_nettype wire

// File: sim.f
src/utf8d_pkg.sv
src/utf8d_front.sv
src/utf8d_queue.sv
src/utf8d_back.sv
src/utf8_stream_decoder.sv
tb/utf8_stream_decoder_test.sv
